// ----- rtl/sbdq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbdq_pkg
// Shared types and constants of the spectrum bin decibel quantiser.
// ----------------------------------------------------------------------------
package sbdq_pkg;

    localparam int LOG_W  = 64;
    localparam int EXP_W  = 6;
    localparam int FRAC_W = 16;
    localparam int MANT_W = 31;
    localparam int REM_W  = 35;
    localparam int DEN_W  = 33;
    localparam int QUO_W  = 8;
    localparam int SEL_W  = 2;

    localparam logic [17:0] DB_PER_LOG2 = 18'd197283;

    localparam logic [1:0] REG_REF   = 2'd0;
    localparam logic [1:0] REG_FLOOR = 2'd1;
    localparam logic [1:0] REG_CEIL  = 2'd2;

    localparam logic [SEL_W-1:0] SEL_ZERO = 2'd0;
    localparam logic [SEL_W-1:0] SEL_FULL = 2'd1;
    localparam logic [SEL_W-1:0] SEL_DIV  = 2'd2;

    localparam logic [23:0] REF_RESET   = 24'h800000;
    localparam logic [16:0] FLOOR_RESET = 17'h19C00;
    localparam logic [16:0] CEIL_RESET  = 17'h00000;

    typedef struct packed {
        logic [MANT_W-1:0] mant_p;
        logic [MANT_W-1:0] mant_r;
        logic [FRAC_W-1:0] frac_p;
        logic [FRAC_W-1:0] frac_r;
        logic [EXP_W-1:0]  exp_p;
        logic [EXP_W-1:0]  exp_r;
        logic              zero;
        logic              last;
    } t_log_word;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
        logic [SEL_W-1:0] sel;
        logic             last;
    } t_div_word;

endpackage

// ----- rtl/sbdq_log_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbdq_log_cell
// One squaring step of the log2 chain; yields one fraction bit per lane.
// ----------------------------------------------------------------------------
module sbdq_log_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  sbdq_pkg::t_log_word  i_word,
    output logic                 o_valid,
    output sbdq_pkg::t_log_word  o_word
);

    logic                          r_valid;
    sbdq_pkg::t_log_word           r_word;
    sbdq_pkg::t_log_word           n_word;
    logic [2*sbdq_pkg::MANT_W-1:0] w_sq_p;
    logic [2*sbdq_pkg::MANT_W-1:0] w_sq_r;
    logic [sbdq_pkg::MANT_W:0]     w_t_p;
    logic [sbdq_pkg::MANT_W:0]     w_t_r;

    always_comb begin
        w_sq_p = (2*sbdq_pkg::MANT_W)'(i_word.mant_p) * (2*sbdq_pkg::MANT_W)'(i_word.mant_p);
        w_sq_r = (2*sbdq_pkg::MANT_W)'(i_word.mant_r) * (2*sbdq_pkg::MANT_W)'(i_word.mant_r);
        w_t_p  = w_sq_p[2*sbdq_pkg::MANT_W-1:sbdq_pkg::MANT_W-1];
        w_t_r  = w_sq_r[2*sbdq_pkg::MANT_W-1:sbdq_pkg::MANT_W-1];
        n_word = i_word;
        n_word.mant_p = w_t_p[sbdq_pkg::MANT_W] ? w_t_p[sbdq_pkg::MANT_W:1]
                                                : w_t_p[sbdq_pkg::MANT_W-1:0];
        n_word.mant_r = w_t_r[sbdq_pkg::MANT_W] ? w_t_r[sbdq_pkg::MANT_W:1]
                                                : w_t_r[sbdq_pkg::MANT_W-1:0];
        n_word.frac_p = {i_word.frac_p[sbdq_pkg::FRAC_W-2:0], w_t_p[sbdq_pkg::MANT_W]};
        n_word.frac_r = {i_word.frac_r[sbdq_pkg::FRAC_W-2:0], w_t_r[sbdq_pkg::MANT_W]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ----- rtl/sbdq_div_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbdq_div_cell
// One restoring step of the level divider; yields one quotient bit.
// ----------------------------------------------------------------------------
module sbdq_div_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  sbdq_pkg::t_div_word  i_word,
    output logic                 o_valid,
    output sbdq_pkg::t_div_word  o_word
);

    logic                        r_valid;
    sbdq_pkg::t_div_word         r_word;
    sbdq_pkg::t_div_word         n_word;
    logic                        w_ge;
    logic [sbdq_pkg::REM_W-1:0]  w_rem;

    always_comb begin
        w_ge   = i_word.rem >= sbdq_pkg::REM_W'(i_word.den);
        w_rem  = w_ge ? (i_word.rem - sbdq_pkg::REM_W'(i_word.den)) : i_word.rem;
        n_word = i_word;
        n_word.rem = {w_rem[sbdq_pkg::REM_W-2:0], 1'b0};
        n_word.quo = {i_word.quo[sbdq_pkg::QUO_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ----- rtl/spectrum_bin_db_quantizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_bin_db_quantizer
// Complex bin to 8-bit decibel level, linear between floor and ceiling.
//
//   channel  dir  contents
//   s_axis   in   tdata: bin_real, bin_imag; tlast: frame_end
//   m_axis   out  tdata: level; tlast: frame_end_out
//   apb      cfg  0x0 ref_level, 0x4 floor_db, 0x8 ceiling_db
//
// One word per cycle unless stalled; 6 front stages (squares, leading
// one, normalise), 16 log2 cells, 5 scaling stages, 8 divider cells, output.
// Reset clears all valid bits and loads register defaults; nothing to sweep.
// A stalled output parks one word in a skid register and freezes the chain.
// ----------------------------------------------------------------------------
module spectrum_bin_db_quantizer #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // bin_real [SB-1:0], bin_imag [2SB-1:SB], zero padding
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // level [7:0]
    output logic [7:0]                             m_axis_tdata,
    output logic                                   m_axis_tlast,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [3:0]                             paddr,
    input  logic [31:0]                            pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready
);

    localparam int SB      = SAMPLE_BITS;
    localparam int SQ_W    = 2 * SAMPLE_BITS;
    localparam int LW      = sbdq_pkg::LOG_W;
    localparam int DIFF_W  = 23;
    localparam int PROD_W  = 42;
    localparam int DB_W    = 26;
    localparam int NUM_W   = 27;
    localparam int SPAN_W  = 26;
    localparam int CFGD_W  = 18;
    localparam int N_LOG   = sbdq_pkg::FRAC_W;
    localparam int N_DIV   = sbdq_pkg::QUO_W;

    function automatic logic [2:0] f_top_idx(input logic [7:0] v);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) idx = 3'(i);
        end
        return idx;
    endfunction

    // configuration
    logic [23:0]        r_ref;
    logic signed [16:0] r_floor;
    logic signed [16:0] r_ceil;
    logic               w_wr;
    logic [23:0]        w_ref_eff;

    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite;
    assign w_ref_eff = (r_ref == '0) ? 24'd1 : r_ref;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref   <= sbdq_pkg::REF_RESET;
            r_floor <= sbdq_pkg::FLOOR_RESET;
            r_ceil  <= sbdq_pkg::CEIL_RESET;
        end else if (w_wr) begin
            case (paddr[3:2])
                sbdq_pkg::REG_REF:   r_ref   <= pwdata[23:0];
                sbdq_pkg::REG_FLOOR: r_floor <= pwdata[16:0];
                sbdq_pkg::REG_CEIL:  r_ceil  <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            sbdq_pkg::REG_REF:   prdata = {8'd0, r_ref};
            sbdq_pkg::REG_FLOOR: prdata = {15'd0, r_floor};
            sbdq_pkg::REG_CEIL:  prdata = {15'd0, r_ceil};
            default:             prdata = 32'd0;
        endcase
    end

    // chain enable: freeze while the skid register holds a word
    logic r_skid_v;
    logic w_en;
    logic w_acc;

    assign w_en          = !r_skid_v;
    assign s_axis_tready = w_en;
    assign w_acc         = s_axis_tvalid && w_en;

    // F0: magnitudes
    logic [SB-1:0] w_re;
    logic [SB-1:0] w_im;
    logic          r_f0_v, r_f0_last;
    logic [SB-1:0] r_mag_re, r_mag_im;

    assign w_re = s_axis_tdata[SB-1:0];
    assign w_im = s_axis_tdata[2*SB-1:SB];

    // F1: squares
    logic            r_f1_v, r_f1_last;
    logic [SQ_W-1:0] r_sq_re, r_sq_im;
    logic [47:0]     r_f1_rsq;

    // F2: power
    logic            r_f2_v, r_f2_last;
    logic [LW-1:0]   r_f2_p, r_f2_r;

    // F3: top non-zero byte
    logic            r_f3_v, r_f3_last, r_f3_zero;
    logic [LW-1:0]   r_f3_p, r_f3_r;
    logic [2:0]      r_hb_p, r_hb_r;
    logic [7:0]      w_bf_p, w_bf_r;

    // F4: leading one
    logic            r_f4_v, r_f4_last, r_f4_zero;
    logic [LW-1:0]   r_f4_p, r_f4_r;
    logic [5:0]      r_e_p, r_e_r;
    logic [7:0]      w_byte_p, w_byte_r;

    // F5: normalise
    logic                r_f5_v;
    sbdq_pkg::t_log_word r_f5_word;
    logic [LW-1:0]       w_norm_p, w_norm_r;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_bf_p[i] = |r_f2_p[8*i +: 8];
            w_bf_r[i] = |r_f2_r[8*i +: 8];
        end
        w_byte_p = r_f3_p[{r_hb_p, 3'b000} +: 8];
        w_byte_r = r_f3_r[{r_hb_r, 3'b000} +: 8];
        w_norm_p = r_f4_p << (6'd63 - r_e_p);
        w_norm_r = r_f4_r << (6'd63 - r_e_r);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_v <= 1'b0;
            r_f1_v <= 1'b0;
            r_f2_v <= 1'b0;
            r_f3_v <= 1'b0;
            r_f4_v <= 1'b0;
            r_f5_v <= 1'b0;
        end else if (w_en) begin
            r_f0_v <= w_acc;
            r_f1_v <= r_f0_v;
            r_f2_v <= r_f1_v;
            r_f3_v <= r_f2_v;
            r_f4_v <= r_f3_v;
            r_f5_v <= r_f4_v;
        end
        if (w_en) begin
            r_f0_last <= s_axis_tlast;
            r_mag_re  <= w_re[SB-1] ? (~w_re + 1'b1) : w_re;
            r_mag_im  <= w_im[SB-1] ? (~w_im + 1'b1) : w_im;

            r_f1_last <= r_f0_last;
            r_sq_re   <= SQ_W'(r_mag_re) * SQ_W'(r_mag_re);
            r_sq_im   <= SQ_W'(r_mag_im) * SQ_W'(r_mag_im);
            r_f1_rsq  <= 48'(w_ref_eff) * 48'(w_ref_eff);

            r_f2_last <= r_f1_last;
            r_f2_p    <= LW'(r_sq_re + r_sq_im);
            r_f2_r    <= LW'(r_f1_rsq);

            r_f3_last <= r_f2_last;
            r_f3_zero <= (w_bf_p == '0);
            r_f3_p    <= r_f2_p;
            r_f3_r    <= r_f2_r;
            r_hb_p    <= f_top_idx(w_bf_p);
            r_hb_r    <= f_top_idx(w_bf_r);

            r_f4_last <= r_f3_last;
            r_f4_zero <= r_f3_zero;
            r_f4_p    <= r_f3_p;
            r_f4_r    <= r_f3_r;
            r_e_p     <= {r_hb_p, f_top_idx(w_byte_p)};
            r_e_r     <= {r_hb_r, f_top_idx(w_byte_r)};

            r_f5_word.mant_p <= w_norm_p[LW-1:LW-sbdq_pkg::MANT_W];
            r_f5_word.mant_r <= w_norm_r[LW-1:LW-sbdq_pkg::MANT_W];
            r_f5_word.frac_p <= '0;
            r_f5_word.frac_r <= '0;
            r_f5_word.exp_p  <= r_e_p;
            r_f5_word.exp_r  <= r_e_r;
            r_f5_word.zero   <= r_f4_zero;
            r_f5_word.last   <= r_f4_last;
        end
    end

    // log2 chain
    logic                w_log_v    [0:N_LOG];
    sbdq_pkg::t_log_word w_log_word [0:N_LOG];

    assign w_log_v[0]    = r_f5_v;
    assign w_log_word[0] = r_f5_word;

    for (genvar g = 0; g < N_LOG; g++) begin : g_log
        sbdq_log_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_log_v[g]),
            .i_word  (w_log_word[g]),
            .o_valid (w_log_v[g+1]),
            .o_word  (w_log_word[g+1])
        );
    end

    // B1..B5: scale to the floor..ceiling range
    sbdq_pkg::t_log_word     w_lw;
    logic signed [DIFF_W-1:0] w_d;
    logic signed [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0]        w_rnd;
    logic signed [NUM_W-1:0]  w_num;
    logic signed [CFGD_W-1:0] w_cdiff;
    logic [sbdq_pkg::REM_W-1:0] w_n;

    logic                     r_b1_v, r_b1_last, r_b1_zero;
    logic signed [DIFF_W-1:0] r_b1_d;
    logic                     r_b2_v, r_b2_last, r_b2_zero;
    logic signed [PROD_W-1:0] r_b2_prod;
    logic                     r_b3_v, r_b3_last, r_b3_zero;
    logic signed [DB_W-1:0]   r_b3_db;
    logic                     r_b4_v, r_b4_last, r_b4_zero;
    logic signed [NUM_W-1:0]  r_b4_num;
    logic signed [SPAN_W-1:0] r_b4_span;
    logic                     r_b5_v;
    sbdq_pkg::t_div_word      r_b5_word;

    always_comb begin
        w_lw    = w_log_word[N_LOG];
        w_d     = DIFF_W'({w_lw.exp_p, w_lw.frac_p}) - DIFF_W'({w_lw.exp_r, w_lw.frac_r});
        w_prod  = PROD_W'(r_b1_d) * PROD_W'(signed'({1'b0, sbdq_pkg::DB_PER_LOG2}));
        w_rnd   = r_b2_prod + (r_b2_prod[PROD_W-1] ? PROD_W'(16'h7FFF) : PROD_W'(16'h8000));
        w_num   = NUM_W'(r_b3_db) - (NUM_W'(r_floor) <<< 8);
        w_cdiff = CFGD_W'(r_ceil) - CFGD_W'(r_floor);
        w_n     = (sbdq_pkg::REM_W'(r_b4_num) << 9) - (sbdq_pkg::REM_W'(r_b4_num) << 1)
                + sbdq_pkg::REM_W'(r_b4_span);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v <= 1'b0;
            r_b2_v <= 1'b0;
            r_b3_v <= 1'b0;
            r_b4_v <= 1'b0;
            r_b5_v <= 1'b0;
        end else if (w_en) begin
            r_b1_v <= w_log_v[N_LOG];
            r_b2_v <= r_b1_v;
            r_b3_v <= r_b2_v;
            r_b4_v <= r_b3_v;
            r_b5_v <= r_b4_v;
        end
        if (w_en) begin
            r_b1_last <= w_lw.last;
            r_b1_zero <= w_lw.zero;
            r_b1_d    <= w_d;

            r_b2_last <= r_b1_last;
            r_b2_zero <= r_b1_zero;
            r_b2_prod <= w_prod;

            r_b3_last <= r_b2_last;
            r_b3_zero <= r_b2_zero;
            r_b3_db   <= w_rnd[16 +: DB_W];

            r_b4_last <= r_b3_last;
            r_b4_zero <= r_b3_zero || w_cdiff[CFGD_W-1] || (w_cdiff == '0);
            r_b4_num  <= w_num;
            r_b4_span <= SPAN_W'(w_cdiff) <<< 8;

            r_b5_word.last <= r_b4_last;
            r_b5_word.rem  <= w_n;
            r_b5_word.den  <= {r_b4_span[24:0], 8'd0};
            r_b5_word.quo  <= '0;
            if (r_b4_zero || r_b4_num[NUM_W-1] || (r_b4_num == '0)) begin
                r_b5_word.sel <= sbdq_pkg::SEL_ZERO;
            end else if (r_b4_num >= NUM_W'(r_b4_span)) begin
                r_b5_word.sel <= sbdq_pkg::SEL_FULL;
            end else begin
                r_b5_word.sel <= sbdq_pkg::SEL_DIV;
            end
        end
    end

    // divider chain
    logic                w_div_v    [0:N_DIV];
    sbdq_pkg::t_div_word w_div_word [0:N_DIV];

    assign w_div_v[0]    = r_b5_v;
    assign w_div_word[0] = r_b5_word;

    for (genvar g = 0; g < N_DIV; g++) begin : g_div
        sbdq_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_div_v[g]),
            .i_word  (w_div_word[g]),
            .o_valid (w_div_v[g+1]),
            .o_word  (w_div_word[g+1])
        );
    end

    // output register and skid
    sbdq_pkg::t_div_word w_fw;
    logic [7:0]          w_fin_level;
    logic                w_fin_v;
    logic                r_out_v, n_out_v, n_skid_v;
    logic [7:0]          r_out_level, n_out_level, r_skid_level, n_skid_level;
    logic                r_out_last, n_out_last, r_skid_last, n_skid_last;

    always_comb begin
        w_fw    = w_div_word[N_DIV];
        w_fin_v = w_div_v[N_DIV];
        case (w_fw.sel)
            sbdq_pkg::SEL_FULL: w_fin_level = 8'd255;
            sbdq_pkg::SEL_DIV:  w_fin_level = w_fw.quo;
            default:            w_fin_level = 8'd0;
        endcase

        n_out_v      = r_out_v;
        n_out_level  = r_out_level;
        n_out_last   = r_out_last;
        n_skid_v     = r_skid_v;
        n_skid_level = r_skid_level;
        n_skid_last  = r_skid_last;
        if (r_skid_v) begin
            if (m_axis_tready) begin
                n_out_level = r_skid_level;
                n_out_last  = r_skid_last;
                n_skid_v    = 1'b0;
            end
        end else if (!r_out_v || m_axis_tready) begin
            n_out_v     = w_fin_v;
            n_out_level = w_fin_level;
            n_out_last  = w_fw.last;
        end else if (w_fin_v) begin
            n_skid_v     = 1'b1;
            n_skid_level = w_fin_level;
            n_skid_last  = w_fw.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
        r_out_level  <= n_out_level;
        r_out_last   <= n_out_last;
        r_skid_level <= n_skid_level;
        r_skid_last  <= n_skid_last;
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_out_level;
    assign m_axis_tlast  = r_out_last;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("skid word held without an output word");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(r_out_v && !m_axis_tready))
        else $error("skid filled while output was free");

    a_no_accept_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> !(s_axis_tvalid && s_axis_tready))
        else $error("word accepted while chain frozen");

endmodule

// ----- sim/tb_spectrum_bin_db_quantizer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spectrum_bin_db_quantizer
// Streams complex bins through the decibel quantiser under several register
// settings and checks each level and frame-end flag against a local model.
// ----------------------------------------------------------------------------
module tb_spectrum_bin_db_quantizer;

    localparam int SB      = 24;
    localparam int DW      = ((2*SB+7)/8)*8;
    localparam int LATENCY = 36;

    typedef struct packed {
        logic [SB-1:0] re;
        logic [SB-1:0] im;
        logic          last;
    } t_bin;

    typedef struct packed {
        logic [7:0] level;
        logic       last;
    } t_level;

    logic            i_clk;
    logic            i_rst_n;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    logic [DW-1:0]   s_axis_tdata;
    logic            s_axis_tlast;
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    logic [7:0]      m_axis_tdata;
    logic            m_axis_tlast;
    logic            psel;
    logic            penable;
    logic            pwrite;
    logic [3:0]      paddr;
    logic [31:0]     pwdata;
    logic [31:0]     prdata;
    logic            pready;

    logic [23:0]     cur_ref;
    logic [16:0]     cur_floor;
    logic [16:0]     cur_ceil;

    t_bin            bin_queue[$];
    t_level          level_queue[$];
    int              errors;
    int              sent;
    int              hold_off;
    bit              calm;
    bit              stall_done;

    spectrum_bin_db_quantizer #(.SAMPLE_BITS(SB)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [63:0] log2_fix(logic [63:0] x);
        logic [63:0] t;
        logic [63:0] m;
        logic [15:0] frac;
        int          e;
        t = x;
        e = 0;
        frac = '0;
        while (t > 1) begin
            t = t >> 1;
            e++;
        end
        m = (e >= 30) ? (x >> (e - 30)) : (x << (30 - e));
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= 64'h8000_0000) begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return (64'(e) << 16) | 64'(frac);
    endfunction

    function automatic t_level quantise(t_bin b);
        t_level       r;
        longint       re, im, d, prod, db, fl, cl, num, span;
        logic [63:0]  p, rf, a;
        re = longint'($signed(b.re));
        im = longint'($signed(b.im));
        p = 64'(re * re) + 64'(im * im);
        rf = (cur_ref == 0) ? 64'd1 : 64'(cur_ref);
        fl = longint'($signed(cur_floor));
        cl = longint'($signed(cur_ceil));
        r.level = 8'd0;
        r.last = b.last;
        if (p != 0 && cl > fl) begin
            d = longint'(log2_fix(p)) - longint'(log2_fix(rf * rf));
            prod = d * 197283;
            a = (prod < 0) ? 64'(-prod) : 64'(prod);
            a = (a + 64'd32768) >> 16;
            db = (prod < 0) ? -longint'(a) : longint'(a);
            num = db - fl * 256;
            span = (cl - fl) * 256;
            if (num <= 0)
                r.level = 8'd0;
            else if (num >= span)
                r.level = 8'd255;
            else
                r.level = 8'((num * 510 + span) / (2 * span));
        end
        return r;
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid)
                sent <= sent + 1;
            if (bin_queue.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
                t_bin b;
                b = bin_queue.pop_front();
                level_queue.push_back(quantise(b));
                s_axis_tdata  <= DW'({b.im, b.re});
                s_axis_tlast  <= b.last;
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else if (!stall_done && sent > 300) begin
            stall_done <= 1'b1;
            hold_off <= 200;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || $urandom_range(99) >= 13;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (level_queue.size() == 0) begin
                $error("unexpected word: level %0d", m_axis_tdata);
                errors++;
            end else begin
                t_level e;
                e = level_queue.pop_front();
                if (m_axis_tdata !== e.level) begin
                    $error("level: expected %0d, got %0d", e.level, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("frame_end_out: expected %0d, got %0d", e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            sbdq_pkg::REG_REF:   cur_ref   = val[23:0];
            sbdq_pkg::REG_FLOOR: cur_floor = val[16:0];
            sbdq_pkg::REG_CEIL:  cur_ceil  = val[16:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (bin_queue.size() > 0 || s_axis_tvalid || level_queue.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [SB-1:0] rand_part();
        case ($urandom_range(5))
            0: return 24'h800000;
            1: return 24'h7FFFFF;
            2: return 24'(int'($urandom_range(16)) - 8);
            3: return 24'($urandom) >> $urandom_range(23);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic add_bin(input logic [SB-1:0] re, input logic [SB-1:0] im,
                           input logic last);
        t_bin b;
        b.re = re;
        b.im = im;
        b.last = last;
        bin_queue.push_back(b);
    endtask

    task automatic random_bins(input int n);
        for (int i = 0; i < n; i++)
            add_bin(rand_part(), rand_part(), ($urandom_range(15) == 0));
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        sent = 0;
        hold_off = 0;
        calm = 1'b0;
        stall_done = 1'b0;
        cur_ref = sbdq_pkg::REF_RESET;
        cur_floor = sbdq_pkg::FLOOR_RESET;
        cur_ceil = sbdq_pkg::CEIL_RESET;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_bin(24'h0, 24'h0, 1'b0);
        add_bin(24'h800000, 24'h800000, 1'b1);
        add_bin(24'h7FFFFF, 24'h7FFFFF, 1'b0);
        add_bin(24'h7FFFFF, 24'h800000, 1'b1);
        add_bin(24'h000001, 24'h0, 1'b0);
        add_bin(24'h0, 24'hFFFFFF, 1'b0);
        add_bin(24'h800000, 24'h0, 1'b0);
        add_bin(24'h5A827A, 24'h5A827A, 1'b1);
        add_bin(24'hAAAAAA, 24'h555555, 1'b0);
        add_bin(24'h555555, 24'hAAAAAA, 1'b1);
        drain();

        reg_write(sbdq_pkg::REG_REF, 32'd0);
        reg_write(sbdq_pkg::REG_FLOOR, 32'h1_0000);
        reg_write(sbdq_pkg::REG_CEIL, 32'h0_FFFF);
        add_bin(24'h0, 24'h0, 1'b0);
        add_bin(24'h000001, 24'h0, 1'b1);
        add_bin(24'h7FFFFF, 24'h800000, 1'b0);
        random_bins(300);
        drain();

        // empty span: ceiling equal to floor, then below it
        reg_write(sbdq_pkg::REG_REF, 32'd1);
        reg_write(sbdq_pkg::REG_CEIL, 32'h1_0000);
        add_bin(24'h123456, 24'h654321, 1'b1);
        random_bins(40);
        drain();
        reg_write(sbdq_pkg::REG_FLOOR, 32'h0_0100);
        reg_write(sbdq_pkg::REG_CEIL, 32'h0_0000);
        random_bins(40);
        drain();

        reg_write(sbdq_pkg::REG_REF, 32'hFF_FFFF);
        reg_write(sbdq_pkg::REG_FLOOR, 32'h1_D000);
        reg_write(sbdq_pkg::REG_CEIL, 32'h0_0000);
        calm = 1'b1;
        random_bins(300);
        drain();
        calm = 1'b0;

        for (int ph = 0; ph < 4; ph++) begin
            int f, c;
            f = -$urandom_range(30000);
            c = f + 1 + $urandom_range(40000);
            if (c > 65535)
                c = 65535;
            reg_write(sbdq_pkg::REG_REF,
                      32'($urandom_range(24'hFFFFFF, 1)) >> $urandom_range(23));
            reg_write(sbdq_pkg::REG_FLOOR, 32'(f));
            reg_write(sbdq_pkg::REG_CEIL, 32'(c));
            random_bins(220);
            drain();
        end

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/sbdq_pkg.sv
rtl/sbdq_log_cell.sv
rtl/sbdq_div_cell.sv
rtl/spectrum_bin_db_quantizer.sv
sim/tb_spectrum_bin_db_quantizer.sv
